// ===== hdl/rtd_pkg.sv =====
// ----------------------------------------------------------------------------
// rtd_pkg
// Shared widths, codes, command/status types and the tile table for the
// run-length tile map decoder.
// ----------------------------------------------------------------------------
package rtd_pkg;

    // Configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam int RESET_IMAGE_WIDTH  = 640;
    localparam int RESET_IMAGE_HEIGHT = 480;
    localparam int MIN_IMAGE_WIDTH    = 32;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_IMAGE_DIM = 4096;
    localparam int DEF_BORDER_TILES  = 7;

    // Field widths
    localparam int CODE_W  = 8;
    localparam int COUNT_W = 8;
    localparam int IDX_W   = 6;
    localparam int RUN_W   = 10;
    localparam int TILE_W  = 8;
    localparam int ROW_W   = 13;
    localparam int COL_W   = 13;
    localparam int ADDR_W  = 26;
    localparam int SEG_W   = 10;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_TUSER_W = 2;

    localparam int TILE_KINDS = 33;
    localparam logic [TILE_W-1:0] TILE_REMAP_FROM = 8'h1B;

    // A run never spans more rows than this past its first segment, so the
    // row count used for the capacity check saturates here.
    localparam int RUN_MAX    = 2**RUN_W - 1;
    localparam int ROWS_CLAMP = (RUN_MAX + MIN_IMAGE_WIDTH) / MIN_IMAGE_WIDTH;
    localparam int RC_W       = $clog2(ROWS_CLAMP + 1);

    // Controller -> datapath
    typedef struct packed {
        logic accept;     // input transaction taken this cycle
        logic setup;      // first setup step: limits, stride, first segment
        logic check;      // second setup step: capacity / overflow check
        logic emit_load;  // load one result into the output register
    } t_rtd_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic run_end;    // terminator code
        logic run_none;   // empty run, or starts beyond last row
        logic out_free;   // output register can take a result
        logic seg_last;   // the result being formed closes this input
    } t_rtd_status;

    // Tile index -> tile code, with the 0x1B -> 0 remap folded in
    function automatic logic [TILE_W-1:0] tile_lookup(input logic [IDX_W-1:0] idx);
        logic [TILE_W-1:0] t;
        unique case (idx)
            6'd0:    t = 8'h00;
            6'd1:    t = 8'h01;
            6'd2:    t = 8'h0A;
            6'd3:    t = 8'h05;
            6'd4:    t = 8'h02;
            6'd5:    t = 8'h07;
            6'd6:    t = 8'h1A;
            6'd7:    t = 8'h04;
            6'd8:    t = 8'h06;
            6'd9:    t = 8'h14;
            6'd10:   t = 8'h0C;
            6'd11:   t = 8'h40;
            6'd12:   t = 8'h44;
            6'd13:   t = 8'h41;
            6'd14:   t = 8'h45;
            6'd15:   t = 8'h42;
            6'd16:   t = 8'h46;
            6'd17:   t = 8'h43;
            6'd18:   t = 8'h47;
            6'd19:   t = 8'h1B;
            6'd20:   t = 8'h16;
            6'd21:   t = 8'h17;
            6'd22:   t = 8'h18;
            6'd23:   t = 8'h19;
            6'd24:   t = 8'h0F;
            6'd25:   t = 8'h10;
            6'd26:   t = 8'h12;
            6'd27:   t = 8'h13;
            6'd28:   t = 8'h1C;
            6'd29:   t = 8'h1D;
            6'd30:   t = 8'h1E;
            6'd31:   t = 8'h1F;
            6'd32:   t = 8'h81;
            default: t = 8'h00;
        endcase
        if (t == TILE_REMAP_FROM) begin
            t = '0;
        end
        return t;
    endfunction

endpackage

// ===== hdl/rle_tilemap_decoder.sv =====
// ----------------------------------------------------------------------------
// rle_tilemap_decoder
// Run-length tile map decoder: two-byte run codes in, row segments out.
// ----------------------------------------------------------------------------
// Each accepted run code passes a setup step (clamped sizes, wrap column,
// row limit, stride exponent) and a check step (a small multiply that checks
// the run against the room left up to the end of the last interior row),
// after which one row segment is produced per cycle by the segment step
// while the output register is free. The next code is taken on the cycle the
// last segment is loaded; an end-of-map code gives one result, an empty or
// dropped run none. The overflow bit of every result already reflects the
// whole run it belongs to. Configuration must be written by the user only
// while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module rle_tilemap_decoder
    import rtd_pkg::*;
#(
    parameter int MAX_IMAGE_DIM = DEF_MAX_IMAGE_DIM,
    parameter int BORDER_TILES  = DEF_BORDER_TILES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // run codes
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // code_byte[7:0], count_byte[15:8]
    // segments
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // tile_value[7:0], row_index[20:8],
                                                     // start_column[33:21],
                                                     // start_address[59:34],
                                                     // segment_length[69:60], zero pad
    output logic                   o_m_axis_tlast,   // last_of_run
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser    // map_end[0], overflow[1]
);

    t_rtd_cmd          w_cmd;
    t_rtd_status       w_status;
    logic [TILE_W-1:0] w_tile;
    logic [ROW_W-1:0]  w_row;
    logic [COL_W-1:0]  w_col;
    logic [ADDR_W-1:0] w_addr;
    logic [SEG_W-1:0]  w_len;
    logic              w_map_end;
    logic              w_ovf;

    rtd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rtd_datapath #(
        .MAX_IMAGE_DIM (MAX_IMAGE_DIM),
        .BORDER_TILES  (BORDER_TILES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_code_byte      (i_s_axis_tdata[CODE_W-1:0]),
        .i_count_byte     (i_s_axis_tdata[CODE_W+COUNT_W-1:CODE_W]),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_out_ready      (i_m_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .o_tile_value     (w_tile),
        .o_row_index      (w_row),
        .o_start_column   (w_col),
        .o_start_address  (w_addr),
        .o_segment_length (w_len),
        .o_last_of_run    (o_m_axis_tlast),
        .o_map_end        (w_map_end),
        .o_overflow       (w_ovf)
    );

    // Result packing, first field in the low bits
    assign o_m_axis_tdata = {2'b00, w_len, w_addr, w_col, w_row, w_tile};
    assign o_m_axis_tuser = {w_ovf, w_map_end};

endmodule

// ===== hdl/rtd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtd_ctrl
// Sequencer: takes one run code, steps it through the setup and check states,
// then issues one segment load per free output slot until the run is done.
// ----------------------------------------------------------------------------
module rtd_ctrl
    import rtd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_rtd_status i_status,
    output t_rtd_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_load;
    logic       w_accept;

    // Next run may enter on the cycle that the current one closes
    assign w_load     = (r_state == ST_EMIT) && i_status.out_free;
    assign o_in_ready = (r_state == ST_IDLE) || (w_load && i_status.seg_last);
    assign w_accept   = i_in_valid && o_in_ready;

    assign o_cmd.accept    = w_accept;
    assign o_cmd.setup     = (r_state == ST_SETUP);
    assign o_cmd.check     = (r_state == ST_CHECK);
    assign o_cmd.emit_load = w_load;

    // State transitions
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_status.run_end)       n_state = ST_EMIT;
                else if (i_status.run_none) n_state = ST_IDLE;
                else                        n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_load && i_status.seg_last) begin
                    n_state = w_accept ? ST_SETUP : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/rtd_datapath.sv =====
// ----------------------------------------------------------------------------
// rtd_datapath
// Configuration registers, map position, run setup (limits, stride exponent,
// overflow prediction) and the per-segment step with its output register.
// ----------------------------------------------------------------------------
module rtd_datapath
    import rtd_pkg::*;
#(
    parameter int MAX_IMAGE_DIM = DEF_MAX_IMAGE_DIM,
    parameter int BORDER_TILES  = DEF_BORDER_TILES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [CODE_W-1:0]    i_code_byte,
    input  logic [COUNT_W-1:0]   i_count_byte,
    input  t_rtd_cmd             i_cmd,
    output t_rtd_status          o_status,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [TILE_W-1:0]    o_tile_value,
    output logic [ROW_W-1:0]     o_row_index,
    output logic [COL_W-1:0]     o_start_column,
    output logic [ADDR_W-1:0]    o_start_address,
    output logic [SEG_W-1:0]     o_segment_length,
    output logic                 o_last_of_run,
    output logic                 o_map_end,
    output logic                 o_overflow
);

    localparam int MAPW_MAX   = MAX_IMAGE_DIM + 2 * BORDER_TILES;
    localparam int POS_W      = $clog2(MAPW_MAX + 1);
    localparam int PW1        = POS_W + 1;
    localparam int SH_MAX     = $clog2(MAPW_MAX);
    localparam int SH_W       = $clog2(SH_MAX + 1);
    localparam int ADDR_INT_W = POS_W + SH_MAX + 1;
    localparam int EXT_W      = ((CFG_W > POS_W) ? CFG_W : POS_W) + 1;
    localparam int CMP_W      = ((RUN_W > POS_W) ? RUN_W : POS_W) + 1;
    localparam int CAP_W      = POS_W + RC_W + 1;

    localparam logic [POS_W-1:0] BORDER_POS = POS_W'(BORDER_TILES);

    // Configuration and map state
    logic [CFG_W-1:0]   r_cfg_width;
    logic [CFG_W-1:0]   r_cfg_height;
    logic [POS_W-1:0]   r_row;
    logic [POS_W-1:0]   r_col;
    logic               r_ovf;

    // Captured run code
    logic [CODE_W-1:0]  r_code;
    logic [COUNT_W-1:0] r_count;

    // Run setup registers
    logic               r_end;
    logic [TILE_W-1:0]  r_tile;
    logic [RUN_W-1:0]   r_rem;
    logic [POS_W-1:0]   r_eff_w;
    logic [POS_W-1:0]   r_wrap;
    logic [POS_W-1:0]   r_limit_m1;
    logic [SH_W-1:0]    r_shift;
    logic               r_row_ok;
    logic [POS_W-1:0]   r_first;
    logic [RC_W-1:0]    r_rows_left;

    // Output register
    logic               r_out_valid;
    logic [TILE_W-1:0]  r_o_tile;
    logic [ROW_W-1:0]   r_o_row;
    logic [COL_W-1:0]   r_o_col;
    logic [ADDR_W-1:0]  r_o_addr;
    logic [SEG_W-1:0]   r_o_len;
    logic               r_o_last;
    logic               r_o_end;
    logic               r_o_ovf;

    // Setup combinational terms
    logic [EXT_W-1:0]   w_w_ext;
    logic [EXT_W-1:0]   w_h_ext;
    logic [POS_W-1:0]   w_eff_w;
    logic [POS_W-1:0]   w_eff_h;
    logic [POS_W-1:0]   w_map_w;
    logic [POS_W-1:0]   w_wrap;
    logic [POS_W-1:0]   w_limit;
    logic [POS_W-1:0]   w_rows_full;
    logic [SH_W-1:0]    w_shift;

    // Check terms
    logic [POS_W+RC_W-1:0] w_prod;
    logic [CAP_W-1:0]      w_cap;
    logic                  w_ovf_hit;

    // Segment step terms
    logic [POS_W-1:0]      w_seg_full;
    logic                  w_wrapped;
    logic [RUN_W-1:0]      w_seg;
    logic                  w_seg_last;
    logic [ADDR_INT_W-1:0] w_addr;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_W'(RESET_IMAGE_WIDTH);
            r_cfg_height <= CFG_W'(RESET_IMAGE_HEIGHT);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped sizes, wrap column and row limit
    always_comb begin
        w_w_ext = EXT_W'(r_cfg_width);
        w_h_ext = EXT_W'(r_cfg_height);
        if (w_w_ext < EXT_W'(MIN_IMAGE_WIDTH))    w_eff_w = POS_W'(MIN_IMAGE_WIDTH);
        else if (w_w_ext > EXT_W'(MAX_IMAGE_DIM)) w_eff_w = POS_W'(MAX_IMAGE_DIM);
        else                                      w_eff_w = POS_W'(w_w_ext);
        if (w_h_ext > EXT_W'(MAX_IMAGE_DIM))      w_eff_h = POS_W'(MAX_IMAGE_DIM);
        else                                      w_eff_h = POS_W'(w_h_ext);
        w_map_w     = w_eff_w + BORDER_POS + BORDER_POS;
        w_wrap      = w_eff_w + BORDER_POS;
        w_limit     = w_eff_h + BORDER_POS;
        w_rows_full = w_limit - r_row - POS_W'(1);
    end

    // Stride exponent: count of powers of two below the map width
    always_comb begin
        w_shift = '0;
        for (int k = 0; k < SH_MAX; k++) begin
            if ((PW1'(1) << k) < PW1'(w_map_w)) begin
                w_shift = w_shift + SH_W'(1);
            end
        end
    end

    // Input capture, first setup step and remaining length
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_code  <= i_code_byte;
            r_count <= i_count_byte;
        end
        if (i_cmd.setup) begin
            r_end      <= (r_code[CODE_W-1:2] >= IDX_W'(TILE_KINDS));
            r_tile     <= tile_lookup(r_code[CODE_W-1:2]);
            r_rem      <= {r_count, r_code[1:0]};
            r_eff_w    <= w_eff_w;
            r_wrap     <= w_wrap;
            r_limit_m1 <= w_limit - POS_W'(1);
            r_shift    <= w_shift;
            r_row_ok   <= (r_row < w_limit);
            r_first    <= (r_col >= w_wrap) ? POS_W'(1) : (w_wrap - r_col);
            if (w_rows_full >= POS_W'(ROWS_CLAMP)) r_rows_left <= RC_W'(ROWS_CLAMP);
            else                                   r_rows_left <= RC_W'(w_rows_full);
        end else if (i_cmd.emit_load && !r_end) begin
            r_rem <= r_rem - w_seg;
        end
    end

    // Capacity left up to the end of the last interior row; a longer run overflows
    always_comb begin
        w_prod    = r_rows_left * r_eff_w;
        w_cap     = CAP_W'(w_prod) + CAP_W'(r_first);
        w_ovf_hit = !r_end && (CAP_W'(r_rem) > (r_row_ok ? w_cap : '0));
    end

    // One segment of the run
    always_comb begin
        w_seg_full = (r_col >= r_wrap) ? POS_W'(1) : (r_wrap - r_col);
        w_wrapped  = (CMP_W'(w_seg_full) <= CMP_W'(r_rem));
        w_seg      = w_wrapped ? RUN_W'(w_seg_full) : r_rem;
        w_seg_last = r_end || (CMP_W'(w_seg_full) >= CMP_W'(r_rem))
                     || (w_wrapped && (r_row >= r_limit_m1));
        w_addr     = (ADDR_INT_W'(r_row) << r_shift) + ADDR_INT_W'(r_col);
    end

    // Position and sticky overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= BORDER_POS;
            r_col <= BORDER_POS;
            r_ovf <= 1'b0;
        end else begin
            if (i_cmd.check && w_ovf_hit) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.emit_load) begin
                if (r_end) begin
                    r_row <= BORDER_POS;
                    r_col <= BORDER_POS;
                end else if (w_wrapped) begin
                    r_row <= r_row + POS_W'(1);
                    r_col <= BORDER_POS;
                end else begin
                    r_col <= r_col + POS_W'(w_seg);
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_o_last <= w_seg_last;
            r_o_end  <= r_end;
            r_o_ovf  <= r_ovf;
            if (r_end) begin
                r_o_tile <= '0;
                r_o_row  <= '0;
                r_o_col  <= '0;
                r_o_addr <= '0;
                r_o_len  <= '0;
            end else begin
                r_o_tile <= r_tile;
                r_o_row  <= ROW_W'(r_row);
                r_o_col  <= COL_W'(r_col);
                r_o_addr <= ADDR_W'(w_addr);
                r_o_len  <= SEG_W'(w_seg);
            end
        end
    end

    assign o_status.run_end  = r_end;
    assign o_status.run_none = (r_rem == '0) || !r_row_ok;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.seg_last = w_seg_last;

    assign o_out_valid      = r_out_valid;
    assign o_tile_value     = r_o_tile;
    assign o_row_index      = r_o_row;
    assign o_start_column   = r_o_col;
    assign o_start_address  = r_o_addr;
    assign o_segment_length = r_o_len;
    assign o_last_of_run    = r_o_last;
    assign o_map_end        = r_o_end;
    assign o_overflow       = r_o_ovf;

    // Checks
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag cleared without reset");

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_seg_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_end) |-> (r_o_len != '0))
        else $error("segment result with zero length");

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_end) |-> (r_o_last && (r_o_len == '0)))
        else $error("end-of-map result malformed");

    a_col_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_load |=> (r_col >= BORDER_POS))
        else $error("column moved into the left border");

endmodule

// ===== tb/rle_tilemap_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_tilemap_decoder_test
// Self-checking bench for the run-length tile map decoder.
// ----------------------------------------------------------------------------
// Run codes go in on the slave stream and row segments come out on the master
// stream. A behavioral segment predictor, which keeps its own position,
// overflow flag and map size, turns every accepted run code into the segments
// it should produce. The checker compares each segment field by field against
// the oldest pending one. A short scripted part covers the reset map, the
// field extremes, the tile remap, empty and dropped runs, the terminator, the
// sticky overflow and a column left past the wrap point. A random part
// follows: maps of random runs under many map sizes. Both streams stall at
// random. Map sizes are changed only while the decoder is idle.
// ----------------------------------------------------------------------------
module rle_tilemap_decoder_test;
    import rtd_pkg::*;

    localparam int MAX_DIM      = DEF_MAX_IMAGE_DIM;
    localparam int BORDER       = DEF_BORDER_TILES;
    localparam int MAX_SEGS     = 33;
    localparam int TOTAL_ITEMS  = 215;
    localparam int SETTLE_CYC   = 8;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int MAX_REPORTS  = 40;

    // One output segment, at the block's widths
    typedef struct packed {
        logic [TILE_W-1:0] tile;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [ADDR_W-1:0] addr;
        logic [SEG_W-1:0]  len;
        logic              last;
        logic              map_end;
        logic              ovf;
    } segment_t;

    typedef enum logic [1:0] {CHK_MODEL, CHK_TYPED, CHK_EMPTY} check_e;
    typedef enum logic {ROW_CFG, ROW_RUN} row_e;

    // One row of the directed script
    typedef struct {
        row_e                 kind;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [CFG_W-1:0]     cfg_val;
        logic [CODE_W-1:0]    code;
        logic [COUNT_W-1:0]   count;
        check_e               chk;
        segment_t             want;
    } script_row_t;

    // Tile codes by index, before the remap
    localparam logic [TILE_W-1:0] TILE_CODES [0:TILE_KINDS-1] = '{
        8'h00, 8'h01, 8'h0A, 8'h05, 8'h02, 8'h07, 8'h1A, 8'h04,
        8'h06, 8'h14, 8'h0C, 8'h40, 8'h44, 8'h41, 8'h45, 8'h42,
        8'h46, 8'h43, 8'h47, 8'h1B, 8'h16, 8'h17, 8'h18, 8'h19,
        8'h0F, 8'h10, 8'h12, 8'h13, 8'h1C, 8'h1D, 8'h1E, 8'h1F,
        8'h81
    };

    // DUT signals; every input is known from time zero
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;

    rle_tilemap_decoder #(
        .MAX_IMAGE_DIM (MAX_DIM),
        .BORDER_TILES  (BORDER)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Predictor state and map size
    int unsigned map_width  = RESET_IMAGE_WIDTH;
    int unsigned map_height = RESET_IMAGE_HEIGHT;
    int unsigned cur_row    = BORDER;
    int unsigned cur_col    = BORDER;
    bit          ovf_seen   = 1'b0;

    segment_t    pending_segs[$];
    script_row_t run_script[$];

    int  errors       = 0;
    int  segs_checked = 0;
    int  ends_checked = 0;
    int  ovf_checked  = 0;
    int  codes_sent   = 0;
    int  maps_random  = 0;
    int  cycles       = 0;
    int  stall_left   = 0;
    bit  no_idle      = 1'b0;

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d segments still pending",
                     cycles, pending_segs.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Idle length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Works out the segments one run code produces and advances the position
    task automatic predict_segments(input logic [CODE_W-1:0] code,
                                    input logic [COUNT_W-1:0] count,
                                    input bit keep);
        int unsigned idx, remaining, wrap, lim, sh, w, h, seg_len;
        logic [63:0] addr;
        segment_t    s;
        segment_t    batch[$];
        idx = code >> 2;
        // Terminator: one end-of-map segment, position back to the corner
        if (idx >= TILE_KINDS) begin
            cur_row = BORDER;
            cur_col = BORDER;
            s = '0;
            s.last = 1'b1;
            s.map_end = 1'b1;
            s.ovf = ovf_seen;
            if (keep) pending_segs.push_back(s);
            return;
        end
        w = map_width;
        if (w < MIN_IMAGE_WIDTH) w = MIN_IMAGE_WIDTH;
        if (w > MAX_DIM) w = MAX_DIM;
        h = map_height;
        if (h > MAX_DIM) h = MAX_DIM;
        remaining = (code & 8'h03) + 4 * count;
        wrap = w + BORDER;
        lim = h + BORDER;
        sh = 0;
        while (sh < 31 && (1 << sh) < w + 2 * BORDER) sh++;
        s = '0;
        s.tile = TILE_CODES[idx];
        if (s.tile == TILE_REMAP_FROM) s.tile = '0;
        // Lay the run out one row segment at a time
        while (remaining > 0 && batch.size() < MAX_SEGS) begin
            if (cur_row >= lim) begin
                ovf_seen = 1'b1;
                break;
            end
            seg_len = (cur_col >= wrap) ? 1 : wrap - cur_col;
            if (seg_len > remaining) seg_len = remaining;
            addr = (64'(cur_row) << sh) + 64'(cur_col);
            s.row = ROW_W'(cur_row);
            s.col = COL_W'(cur_col);
            s.addr = addr[ADDR_W-1:0];
            s.len = SEG_W'(seg_len);
            batch.push_back(s);
            remaining -= seg_len;
            cur_col += seg_len;
            if (cur_col >= wrap) begin
                cur_col = BORDER;
                cur_row++;
            end
        end
        // Overflow reflects the whole run; last marks the final segment
        foreach (batch[k]) begin
            batch[k].ovf = ovf_seen;
            batch[k].last = (k == batch.size() - 1);
            if (keep) pending_segs.push_back(batch[k]);
        end
    endtask

    // Configuration write, one register per call
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(val);
        @(posedge i_clk);
        if (idx == CFG_IMAGE_WIDTH) map_width = val & 32'h1FFF;
        else if (idx == CFG_IMAGE_HEIGHT) map_height = val & 32'h1FFF;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits for every pending segment, then lets a dropped run finish
    task automatic drain_block();
        i_s_axis_tvalid <= 1'b0;
        while (pending_segs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Sends one run code and records what it should produce
    task automatic send_run(input logic [CODE_W-1:0] code, input logic [COUNT_W-1:0] count,
                            input check_e chk, input segment_t want);
        int gap;
        gap = (no_idle || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {count, code};
        do @(posedge i_clk); while (!o_s_axis_tready);
        // transaction taken at this edge
        codes_sent++;
        predict_segments(code, count, chk == CHK_MODEL);
        if (chk == CHK_TYPED) pending_segs.push_back(want);
    endtask

    function automatic script_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input int unsigned val);
        script_row_t r;
        r.kind = ROW_CFG;
        r.cfg_idx = idx;
        r.cfg_val = CFG_W'(val);
        r.code = '0;
        r.count = '0;
        r.chk = CHK_MODEL;
        r.want = '0;
        return r;
    endfunction

    function automatic script_row_t run_row(input logic [CODE_W-1:0] code,
                                            input logic [COUNT_W-1:0] count,
                                            input check_e chk);
        script_row_t r;
        r.kind = ROW_RUN;
        r.cfg_idx = '0;
        r.cfg_val = '0;
        r.code = code;
        r.count = count;
        r.chk = chk;
        r.want = '0;
        return r;
    endfunction

    // Run with a single segment written out by hand
    function automatic script_row_t typed_row(input logic [CODE_W-1:0] code,
                                              input logic [COUNT_W-1:0] count,
                                              input int unsigned tile, row, col, addr, len,
                                              input bit map_end, ovf);
        script_row_t r;
        r = run_row(code, count, CHK_TYPED);
        r.want.tile = TILE_W'(tile);
        r.want.row = ROW_W'(row);
        r.want.col = COL_W'(col);
        r.want.addr = ADDR_W'(addr);
        r.want.len = SEG_W'(len);
        r.want.last = 1'b1;
        r.want.map_end = map_end;
        r.want.ovf = ovf;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, name, want, got);
        end
    endtask

    // Output stall generator
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < 25) begin
            stall_left <= pick_gap() - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Segment checker
    always @(posedge i_clk) begin
        segment_t got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.tile    = o_m_axis_tdata[7:0];
            got.row     = o_m_axis_tdata[20:8];
            got.col     = o_m_axis_tdata[33:21];
            got.addr    = o_m_axis_tdata[59:34];
            got.len     = o_m_axis_tdata[69:60];
            got.last    = o_m_axis_tlast;
            got.map_end = o_m_axis_tuser[0];
            got.ovf     = o_m_axis_tuser[1];
            if (pending_segs.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: segment with nothing pending, got 0x%0h",
                             $time, got);
            end else begin
                want = pending_segs.pop_front();
                compare_field("tile_value", 32'(want.tile), 32'(got.tile));
                compare_field("row_index", 32'(want.row), 32'(got.row));
                compare_field("start_column", 32'(want.col), 32'(got.col));
                compare_field("start_address", 32'(want.addr), 32'(got.addr));
                compare_field("segment_length", 32'(want.len), 32'(got.len));
                compare_field("last_of_run", 32'(want.last), 32'(got.last));
                compare_field("map_end", 32'(want.map_end), 32'(got.map_end));
                compare_field("overflow", 32'(want.ovf), 32'(got.ovf));
                segs_checked++;
                if (want.map_end) ends_checked++;
                if (want.ovf) ovf_checked++;
            end
        end
    end

    // Stimulus
    initial begin
        logic [CODE_W-1:0]  code;
        logic [COUNT_W-1:0] count;
        int unsigned        w, h;
        int                 r, map_len;

        // Reset map 640 x 480: stride exponent 10
        run_script.push_back(typed_row(8'hFF, 8'h00, 0, 0, 0, 0, 0, 1, 0));
        run_script.push_back(typed_row(8'h01, 8'h00, 8'h00, 7, 7, 7175, 1, 0, 0));
        run_script.push_back(typed_row(8'h83, 8'h00, 8'h81, 7, 8, 7176, 3, 0, 0));
        // tile 0x1B comes out as 0
        run_script.push_back(typed_row(8'h4E, 8'h00, 8'h00, 7, 11, 7179, 2, 0, 0));
        run_script.push_back(run_row(8'h08, 8'h00, CHK_EMPTY));
        run_script.push_back(run_row(8'h7F, 8'hFF, CHK_MODEL));
        run_script.push_back(run_row(8'h7C, 8'h01, CHK_MODEL));
        run_script.push_back(typed_row(8'h84, 8'hFF, 0, 0, 0, 0, 0, 1, 0));
        run_script.push_back(run_row(8'h2B, 8'h05, CHK_MODEL));
        // Narrowest map, one interior row: the long run overflows
        run_script.push_back(cfg_row(CFG_IMAGE_WIDTH, 0));
        run_script.push_back(cfg_row(CFG_IMAGE_HEIGHT, 1));
        run_script.push_back(run_row(8'h03, 8'h00, CHK_MODEL));
        run_script.push_back(run_row(8'h5F, 8'hFF, CHK_MODEL));
        run_script.push_back(run_row(8'h40, 8'h10, CHK_EMPTY));
        run_script.push_back(typed_row(8'hFC, 8'h00, 0, 0, 0, 0, 0, 1, 1));
        // Zero height drops every run
        run_script.push_back(cfg_row(CFG_IMAGE_HEIGHT, 0));
        run_script.push_back(run_row(8'h05, 8'h03, CHK_EMPTY));
        // Oversized map, clamped
        run_script.push_back(cfg_row(CFG_IMAGE_WIDTH, 8191));
        run_script.push_back(cfg_row(CFG_IMAGE_HEIGHT, 8191));
        run_script.push_back(run_row(8'h7B, 8'hFF, CHK_MODEL));
        run_script.push_back(run_row(8'h7B, 8'hFF, CHK_MODEL));
        run_script.push_back(run_row(8'h44, 8'hFF, CHK_MODEL));
        // Narrow the map mid-row: column now sits past the wrap point
        run_script.push_back(cfg_row(CFG_IMAGE_WIDTH, 32));
        run_script.push_back(run_row(8'h31, 8'h02, CHK_MODEL));
        run_script.push_back(run_row(8'h80, 8'hFF, CHK_MODEL));
        run_script.push_back(cfg_row(CFG_IMAGE_WIDTH, 4096));
        run_script.push_back(cfg_row(CFG_IMAGE_HEIGHT, 4096));
        run_script.push_back(run_row(8'h82, 8'h00, CHK_MODEL));
        // Overflow is sticky across map ends
        run_script.push_back(typed_row(8'h87, 8'hFF, 0, 0, 0, 0, 0, 1, 1));
        run_script.push_back(run_row(8'h55, 8'hAA, CHK_MODEL));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part
        foreach (run_script[i]) begin
            if (run_script[i].kind == ROW_CFG) begin
                drain_block();
                write_cfg(run_script[i].cfg_idx, run_script[i].cfg_val);
            end else begin
                send_run(run_script[i].code, run_script[i].count,
                         run_script[i].chk, run_script[i].want);
            end
        end

        // Random maps, each under a fresh map size
        while (codes_sent < TOTAL_ITEMS) begin
            drain_block();
            r = $urandom_range(0, 99);
            if (r < 8) w = $urandom_range(0, 31);
            else if (r < 14) w = 4096;
            else if (r < 18) w = $urandom_range(4097, 8191);
            else if (r < 22) w = 32;
            else w = $urandom_range(32, 96);
            r = $urandom_range(0, 99);
            if (r < 8) h = 0;
            else if (r < 14) h = 1;
            else if (r < 18) h = $urandom_range(4096, 8191);
            else if (r < 24) h = $urandom_range(100, 480);
            else h = $urandom_range(1, 10);
            write_cfg(CFG_IMAGE_WIDTH, w);
            write_cfg(CFG_IMAGE_HEIGHT, h);
            no_idle = ($urandom_range(0, 4) == 0);
            map_len = $urandom_range(12, 32);
            for (int k = 0; k < map_len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    // noise: any code, terminators included
                    code = CODE_W'($urandom);
                    count = COUNT_W'($urandom);
                end else if (r < 11) begin
                    code = {6'($urandom_range(0, TILE_KINDS - 1)), 2'b00};
                    count = '0;
                end else begin
                    code = {6'($urandom_range(0, TILE_KINDS - 1)), 2'($urandom)};
                    r = $urandom_range(0, 99);
                    if (r < 70) count = COUNT_W'($urandom_range(0, 3));
                    else if (r < 90) count = COUNT_W'($urandom_range(4, 40));
                    else count = COUNT_W'($urandom_range(41, 255));
                end
                send_run(code, count, CHK_MODEL, '0);
            end
            // Most maps are closed; an open one carries its position over
            if ($urandom_range(0, 99) < 80) begin
                code = {6'($urandom_range(TILE_KINDS, 63)), 2'($urandom)};
                count = COUNT_W'($urandom);
                send_run(code, count, CHK_MODEL, '0);
            end
            maps_random++;
        end

        no_idle = 1'b0;
        drain_block();

        $display("Checked %0d segments (%0d map ends, %0d with overflow) from %0d run codes",
                 segs_checked, ends_checked, ovf_checked, codes_sent);
        $display("Scripted rows: %0d, random maps: %0d, map sizes from clamped to oversized",
                 run_script.size(), maps_random);
        if (errors == 0 && pending_segs.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d segments never arrived", errors, pending_segs.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
